// ===== design/has_pkg.sv =====
package has_pkg;

  // key and hash constants
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned HASH_SHIFT = 4;
  localparam logic [31:0] HASH_MULT  = 32'd2654435761;
  localparam int unsigned FLAG_BIT   = 63;

  // default geometry of the store
  localparam int unsigned DEF_BUCKETS      = 256;
  localparam int unsigned DEF_SLOTS        = 8;
  localparam int unsigned DEF_SEGMENTS     = 4;

  // entries of the request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    MODE_TEST   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_ERASE  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    STAT_NONE     = 3'd0,
    STAT_INSERTED = 3'd1,
    STAT_NEW_SEG  = 3'd2,
    STAT_ERASED   = 3'd3,
    STAT_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    mode_e              mode;
    logic [ADDR_W-1:0]  address;
  } req_t;

endpackage

// ===== design/hashed_address_set.sv =====
// hashed address set
// requests carry mode_i (test, test-or-insert, erase, clear) and address_i. a
// request is taken at a rising edge with start high and busy low. each request
// gives one result: result_valid_o is high for exactly one cycle with
// present_o and status_o; the receiver cannot stall and must take it then.
// a front stage hashes the address into a bucket and hands the request to a
// two-entry queue, so new requests are taken while the back is still scanning.
// the back reads one bucket segment (all its slots in one memory row) per
// cycle, stops at the first empty or matching slot, and writes back at most
// one slot. a request scans 1 to MAX_SEGMENTS segments and, from accept, passes
// through the front stage register, the queue, and the back's idle and scan
// states before its result is registered. a clear sweeps every row, one per
// cycle, in the back. after reset the same sweep runs with busy high; busy also
// rises when the queue is full while the front stage holds a request.
module hashed_address_set #(
  parameter int unsigned BUCKETS           = has_pkg::DEF_BUCKETS,
  parameter int unsigned SLOTS_PER_SEGMENT = has_pkg::DEF_SLOTS,
  parameter int unsigned MAX_SEGMENTS      = has_pkg::DEF_SEGMENTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [63:0] address_i,
  output logic        result_valid_o,
  output logic        present_o,
  output logic [2:0]  status_o
);
  import has_pkg::*;

  localparam int unsigned BW = $clog2(BUCKETS);

  logic          init;
  logic          q_full;
  logic          push;
  req_t          f_req;
  logic [BW-1:0] f_bucket;
  logic          q_valid;
  logic          q_pop;
  req_t          q_req;
  logic [BW-1:0] q_bucket;

  // hash and accept
  has_front #(
    .BUCKETS (BUCKETS),
    .BW      (BW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .mode_i    (mode_i),
    .address_i (address_i),
    .busy_o    (busy),
    .hold_i    (init),
    .q_full_i  (q_full),
    .push_o    (push),
    .req_o     (f_req),
    .bucket_o  (f_bucket)
  );

  // request queue
  has_queue #(
    .BW (BW)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .req_i    (f_req),
    .bucket_i (f_bucket),
    .full_o   (q_full),
    .pop_i    (q_pop),
    .valid_o  (q_valid),
    .req_o    (q_req),
    .bucket_o (q_bucket)
  );

  // bucket scan and slot store
  has_back #(
    .BUCKETS           (BUCKETS),
    .SLOTS_PER_SEGMENT (SLOTS_PER_SEGMENT),
    .MAX_SEGMENTS      (MAX_SEGMENTS),
    .BW                (BW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_req_i        (q_req),
    .q_bucket_i     (q_bucket),
    .q_pop_o        (q_pop),
    .init_o         (init),
    .result_valid_o (result_valid_o),
    .present_o      (present_o),
    .status_o       (status_o)
  );

endmodule

// ===== design/has_front.sv =====
module has_front #(
  parameter int unsigned BUCKETS = has_pkg::DEF_BUCKETS,
  parameter int unsigned BW      = $clog2(BUCKETS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           mode_i,
  input  logic [63:0]          address_i,
  output logic                 busy_o,
  input  logic                 hold_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output has_pkg::req_t        req_o,
  output logic [BW-1:0]        bucket_o
);
  import has_pkg::*;

  localparam logic [BW-1:0] BUCKET_MASK = BW'(BUCKETS - 1);

  logic            valid_q;
  req_t            req_q;
  logic [BW-1:0]   bucket_q;
  logic [BW-1:0]   bucket_d;
  logic [2*BW-1:0] prod;
  logic            accept;

  // bucket hash: only the low bits of the product are kept
  always_comb begin
    prod     = (2*BW)'(address_i[HASH_SHIFT +: BW]) * (2*BW)'(HASH_MULT[BW-1:0]);
    bucket_d = prod[BW-1:0] & BUCKET_MASK;
  end

  // stage moves on whenever the queue has room
  assign push_o   = valid_q && !q_full_i;
  assign busy_o   = hold_i || (valid_q && q_full_i);
  assign accept   = start_i && !busy_o;
  assign req_o    = req_q;
  assign bucket_o = bucket_q;

  // request stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  // request stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.mode    <= mode_e'(mode_i);
      req_q.address <= address_i;
      bucket_q      <= bucket_d;
    end
  end

endmodule

// ===== design/has_queue.sv =====
module has_queue #(
  parameter int unsigned BW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  has_pkg::req_t    req_i,
  input  logic [BW-1:0]    bucket_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output has_pkg::req_t    req_o,
  output logic [BW-1:0]    bucket_o
);
  import has_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  req_t          req_q    [QUEUE_DEPTH];
  logic [BW-1:0] bucket_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [CW-1:0] count_q;

  assign full_o   = (count_q == CW'(QUEUE_DEPTH));
  assign valid_o  = (count_q != '0);
  assign req_o    = req_q[rd_ptr_q];
  assign bucket_o = bucket_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      req_q[wr_ptr_q]    <= req_i;
      bucket_q[wr_ptr_q] <= bucket_i;
    end
  end

endmodule

// ===== design/has_back.sv =====
module has_back #(
  parameter int unsigned BUCKETS           = has_pkg::DEF_BUCKETS,
  parameter int unsigned SLOTS_PER_SEGMENT = has_pkg::DEF_SLOTS,
  parameter int unsigned MAX_SEGMENTS      = has_pkg::DEF_SEGMENTS,
  parameter int unsigned BW                = $clog2(BUCKETS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  has_pkg::req_t    q_req_i,
  input  logic [BW-1:0]    q_bucket_i,
  output logic             q_pop_o,
  output logic             init_o,
  output logic             result_valid_o,
  output logic             present_o,
  output logic [2:0]       status_o
);
  import has_pkg::*;

  localparam int unsigned ROWS   = BUCKETS * MAX_SEGMENTS;
  localparam int unsigned ROW_AW = $clog2(ROWS);
  localparam int unsigned SW     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned LW     = (SLOTS_PER_SEGMENT > 1) ? $clog2(SLOTS_PER_SEGMENT) : 1;
  localparam logic [ADDR_W-1:0] FLAG = ADDR_W'(1) << FLAG_BIT;

  typedef logic [SLOTS_PER_SEGMENT-1:0][ADDR_W-1:0] row_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_CLEAR
  } state_e;

  state_e            state_q;
  mode_e             mode_q;
  logic [ADDR_W-1:0] key_q;
  logic [ROW_AW-1:0] row_q;
  logic [SW-1:0]     seg_q;
  logic              result_valid_q;
  logic              present_q;
  status_e           status_q;

  row_t              store_q [ROWS];
  row_t              rdata_q;

  logic              rd_en;
  logic [ROW_AW-1:0] rd_row;
  logic              wr_en;
  logic [ROW_AW-1:0] wr_row;
  row_t              wr_data;

  logic              stop_any;
  logic              stop_match;
  logic [LW-1:0]     fidx;
  logic              last_seg;
  logic              scan_done;
  logic              slot_write;
  logic [ADDR_W-1:0] slot_value;
  status_e           status_d;
  logic              clear_last;

  // find first slot that is empty or matches the key
  always_comb begin
    stop_any   = 1'b0;
    stop_match = 1'b0;
    fidx       = '0;
    for (int j = SLOTS_PER_SEGMENT - 1; j >= 0; j--) begin
      if (rdata_q[j] == '0 || rdata_q[j] == key_q) begin
        stop_any   = 1'b1;
        stop_match = (rdata_q[j] == key_q);
        fidx       = LW'(j);
      end
    end
  end

  // scan outcome for the segment in rdata_q
  always_comb begin
    last_seg   = (seg_q == SW'(MAX_SEGMENTS - 1));
    scan_done  = stop_any || last_seg;
    slot_write = 1'b0;
    slot_value = key_q;
    status_d   = STAT_NONE;
    if (mode_q == MODE_INSERT && !stop_match) begin
      if (stop_any) begin
        slot_write = 1'b1;
        status_d   = (fidx == '0 && seg_q != '0) ? STAT_NEW_SEG : STAT_INSERTED;
      end else begin
        status_d   = STAT_FULL;
      end
    end else if (mode_q == MODE_ERASE && stop_match) begin
      slot_write = 1'b1;
      slot_value = FLAG;
      status_d   = STAT_ERASED;
    end
  end

  // memory port control
  always_comb begin
    clear_last = (row_q == ROW_AW'(ROWS - 1));
    q_pop_o    = (state_q == ST_IDLE) && q_valid_i;
    rd_en      = 1'b0;
    rd_row     = row_q + 1'b1;
    wr_en      = 1'b0;
    wr_row     = row_q;
    wr_data    = '0;
    unique case (state_q)
      ST_IDLE: begin
        rd_en  = q_valid_i && (q_req_i.mode != MODE_CLEAR);
        rd_row = ROW_AW'(ROW_AW'(q_bucket_i) * ROW_AW'(MAX_SEGMENTS));
      end
      ST_SCAN: begin
        rd_en = !scan_done;
        wr_en = stop_any && slot_write;
        for (int j = 0; j < SLOTS_PER_SEGMENT; j++) begin
          wr_data[j] = (LW'(j) == fidx) ? slot_value : rdata_q[j];
        end
      end
      ST_INIT, ST_CLEAR: begin
        wr_en = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // slot store, one segment per row
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_row] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= store_q[rd_row];
    end
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_INIT;
      mode_q         <= MODE_TEST;
      key_q          <= '0;
      row_q          <= '0;
      seg_q          <= '0;
      result_valid_q <= 1'b0;
      present_q      <= 1'b0;
      status_q       <= STAT_NONE;
    end else begin
      result_valid_q <= 1'b0;
      unique case (state_q)
        ST_INIT: begin
          row_q <= row_q + 1'b1;
          if (clear_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid_i) begin
            mode_q <= q_req_i.mode;
            key_q  <= q_req_i.address | FLAG;
            seg_q  <= '0;
            if (q_req_i.mode == MODE_CLEAR) begin
              row_q   <= '0;
              state_q <= ST_CLEAR;
            end else begin
              row_q   <= rd_row;
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            result_valid_q <= 1'b1;
            present_q      <= stop_match;
            status_q       <= status_d;
            state_q        <= ST_IDLE;
          end else begin
            row_q <= rd_row;
            seg_q <= seg_q + 1'b1;
          end
        end
        ST_CLEAR: begin
          row_q <= row_q + 1'b1;
          if (clear_last) begin
            result_valid_q <= 1'b1;
            present_q      <= 1'b0;
            status_q       <= STAT_NONE;
            state_q        <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign init_o         = (state_q == ST_INIT);
  assign result_valid_o = result_valid_q;
  assign present_o      = present_q;
  assign status_o       = status_q;

`ifndef SYNTH
  // result strobes are never on consecutive cycles
  a_result_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |=> !result_valid_q)
    else $error("result strobe on consecutive cycles");

  // a full bucket never reports a hit
  a_full_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_q && status_q == STAT_FULL) |-> !present_q)
    else $error("bucket full with present set");

  // no request is taken before the start-up clear finishes
  a_no_pop_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> (!q_pop_o && !result_valid_q))
    else $error("request taken during start-up clear");

  // a scan write only follows a scan that stopped in this segment
  a_write_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && wr_en) |-> (scan_done && !rd_en))
    else $error("slot write without a finished scan");
`endif

endmodule

// ===== verif/tb_hashed_address_set.sv =====
`timescale 1ns / 100ps

module tb_hashed_address_set;
  import has_pkg::*;

  // geometry of the set under test
  localparam int unsigned BUCKETS       = DEF_BUCKETS;
  localparam int unsigned SLOTS         = DEF_SLOTS;
  localparam int unsigned SEGMENTS      = DEF_SEGMENTS;
  localparam int unsigned BUCKET_SLOTS  = SLOTS * SEGMENTS;
  localparam int unsigned STORE_WORDS   = BUCKETS * BUCKET_SLOTS;
  localparam logic [63:0] KEY_FLAG      = 64'd1 << FLAG_BIT;

  // run length and timing
  localparam int unsigned TOTAL_REQUESTS = 950;
  localparam int unsigned WATCHDOG_LIMIT = 6000;
  localparam int unsigned TAIL_CYCLES    = 24;
  localparam logic [63:0] FILL_STEP      = 64'h1000;

  // one row of the directed table; count > 1 repeats the row with FILL_STEP
  typedef struct packed {
    mode_e       mode;
    logic [63:0] addr;
    logic [7:0]  count;
    logic        typed;
    logic        present;
    status_e     status;
  } dir_row_t;

  typedef struct packed {
    logic        present;
    status_e     status;
    mode_e       mode;
    logic [63:0] address;
  } answer_t;

  localparam int unsigned DIR_ROWS = 19;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{MODE_TEST,   64'h0,                  8'd1, 1'b1, 1'b0, STAT_NONE},
    '{MODE_INSERT, 64'h0,                  8'd1, 1'b1, 1'b0, STAT_INSERTED},
    '{MODE_TEST,   64'h0,                  8'd1, 1'b1, 1'b1, STAT_NONE},
    '{MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 1'b1, 1'b0, STAT_INSERTED},
    '{MODE_TEST,   64'h7FFF_FFFF_FFFF_FFFF, 8'd1, 1'b1, 1'b1, STAT_NONE},
    '{MODE_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 8'd1, 1'b1, 1'b1, STAT_NONE},
    '{MODE_ERASE,  64'h0,                  8'd1, 1'b1, 1'b1, STAT_ERASED},
    '{MODE_TEST,   64'h0,                  8'd1, 1'b1, 1'b1, STAT_NONE},
    '{MODE_TEST,   64'h8000_0000_0000_0000, 8'd1, 1'b1, 1'b1, STAT_NONE},
    '{MODE_ERASE,  64'h8000_0000_0000_0000, 8'd1, 1'b1, 1'b1, STAT_ERASED},
    '{MODE_ERASE,  64'h5,                  8'd1, 1'b1, 1'b0, STAT_NONE},
    '{MODE_INSERT, 64'h5,                  8'd1, 1'b1, 1'b0, STAT_INSERTED},
    '{MODE_TEST,   64'h8000_0000_0000_0005, 8'd1, 1'b1, 1'b1, STAT_NONE},
    '{MODE_INSERT, 64'h1005,               8'd9, 1'b0, 1'b0, STAT_NONE},
    '{MODE_INSERT, 64'h0123_4567_89AB_CDEF, 8'd1, 1'b0, 1'b0, STAT_NONE},
    '{MODE_ERASE,  64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 1'b1, 1'b1, STAT_ERASED},
    '{MODE_CLEAR,  64'hDEAD_BEEF_0000_0000, 8'd1, 1'b1, 1'b0, STAT_NONE},
    '{MODE_TEST,   64'h5,                  8'd1, 1'b1, 1'b0, STAT_NONE},
    '{MODE_TEST,   64'h0,                  8'd1, 1'b1, 1'b0, STAT_NONE}
  };

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  logic [1:0]  mode_i    = '0;
  logic [63:0] address_i = '0;
  logic        result_valid_o;
  logic        present_o;
  logic [2:0]  status_o;

  // shadow copy of the slot store
  logic [63:0]  shadow_slots [STORE_WORDS];
  answer_t      pending_answers [$];
  logic [63:0]  known_addrs [$];
  logic [7:0]   hot_tag = 8'h00;
  int unsigned  burst_left = 8;
  int unsigned  requests_sent = 0;
  int unsigned  mismatches = 0;
  int unsigned  stall_cycles = 0;
  int unsigned  status_seen [5] = '{default: 0};
  int unsigned  clears_sent = 0;
  int unsigned  hits_seen = 0;

  hashed_address_set #(
    .BUCKETS          (BUCKETS),
    .SLOTS_PER_SEGMENT(SLOTS),
    .MAX_SEGMENTS     (SEGMENTS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .address_i     (address_i),
    .result_valid_o(result_valid_o),
    .present_o     (present_o),
    .status_o      (status_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // bucket chosen by the multiplicative hash
  function automatic int unsigned bucket_index(input logic [63:0] addr);
    logic [63:0] product;
    product = (addr >> HASH_SHIFT) * {32'd0, HASH_MULT};
    return int'(product & 64'(BUCKETS - 1));
  endfunction

  // scan the bucket, apply the request to the shadow store, give the answer
  function automatic void set_access(input mode_e mode, input logic [63:0] addr,
                                     output logic present, output status_e status);
    logic [63:0] key;
    int unsigned base;
    int unsigned pos;
    logic        hit;
    logic        done;
    key     = addr | KEY_FLAG;
    base    = bucket_index(addr) * BUCKET_SLOTS;
    pos     = BUCKET_SLOTS;
    hit     = 1'b0;
    done    = 1'b0;
    present = 1'b0;
    status  = STAT_NONE;
    if (mode == MODE_CLEAR) begin
      foreach (shadow_slots[w]) shadow_slots[w] = '0;
      return;
    end
    for (int i = 0; i < BUCKET_SLOTS; i++) begin
      if (!done && shadow_slots[base + i] == '0) begin
        pos  = i;
        done = 1'b1;
      end else if (!done && shadow_slots[base + i] == key) begin
        pos  = i;
        hit  = 1'b1;
        done = 1'b1;
      end
    end
    present = hit;
    if (mode == MODE_INSERT && !hit) begin
      if (pos == BUCKET_SLOTS) begin
        status = STAT_FULL;
      end else begin
        shadow_slots[base + pos] = key;
        status = (pos != 0 && pos % SLOTS == 0) ? STAT_NEW_SEG : STAT_INSERTED;
      end
    end else if (mode == MODE_ERASE && hit) begin
      shadow_slots[base + pos] = KEY_FLAG;
      status = STAT_ERASED;
    end
  endfunction

  // random address that lands in the bucket selected by tag
  function automatic logic [63:0] addr_in_bucket(input logic [7:0] tag);
    logic [63:0] addr;
    addr       = {$urandom, $urandom};
    addr[11:4] = tag;
    return addr;
  endfunction

  // address mix: known keys, tombstone-like keys, hot bucket, anything
  function automatic logic [63:0] pick_address();
    logic [63:0] addr;
    int unsigned r;
    r    = $urandom_range(0, 99);
    addr = {$urandom, $urandom};
    if (r < 40 && known_addrs.size() != 0) begin
      addr     = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
      addr[63] = 1'($urandom_range(0, 1));
    end else if (r < 55) begin
      case ($urandom_range(0, 3))
        0: addr = '0;
        1: addr = KEY_FLAG;
        2: addr = '1;
        default: addr = ~KEY_FLAG;
      endcase
    end else if (r < 75) begin
      addr[11:4] = hot_tag;
    end
    return addr;
  endfunction

  task automatic report_mismatch(input string what, input answer_t exp,
                                 input logic [2:0] got);
    $display("[%0t] mismatch %s: mode %s addr %h expected %0d got %0d", $realtime, what,
             exp.mode.name(), exp.address,
             (what == "present") ? exp.present : exp.status, got);
    mismatches++;
  endtask

  // drive one request and hold it until taken; pace the sender in bursts
  task automatic issue_request(input mode_e mode, input logic [63:0] addr,
                               input logic typed, input logic exp_present,
                               input status_e exp_status);
    answer_t answer;
    logic    present;
    status_e status;
    start     <= 1'b1;
    mode_i    <= mode;
    address_i <= addr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    set_access(mode, addr, present, status);
    answer.present = typed ? exp_present : present;
    answer.status  = typed ? exp_status : status;
    answer.mode    = mode;
    answer.address = addr;
    pending_answers.push_back(answer);
    requests_sent++;
    status_seen[status]++;
    hits_seen += present;
    if (mode == MODE_CLEAR) clears_sent++;
    if (mode == MODE_INSERT) begin
      known_addrs.push_back(addr);
      if (known_addrs.size() > 64) void'(known_addrs.pop_front());
    end
    burst_left = burst_left - 1;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                               : $urandom_range(1, 20);
    end
  endtask

  // hold off until every answer is back
  task automatic drain_set();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_answers.size() != 0);
  endtask

  // result checker and watchdog
  always @(posedge clk_i) begin
    answer_t exp;
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", stall_cycles);
        $display("Regression FAIL");
        $finish;
      end
      if (result_valid_o) begin
        if (pending_answers.size() == 0) begin
          $display("[%0t] mismatch: unexpected result present %0d status %0d", $realtime,
                   present_o, status_o);
          mismatches++;
        end else begin
          exp = pending_answers.pop_front();
          if (present_o !== exp.present) report_mismatch("present", exp, {2'b0, present_o});
          if (status_o !== exp.status) report_mismatch("status", exp, status_o);
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [63:0] addr;
    logic [63:0] seq_addrs [$];
    int unsigned seq_len;
    int unsigned r;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int row = 0; row < DIR_ROWS; row++) begin
      addr = DIR_TABLE[row].addr;
      for (int k = 0; k < DIR_TABLE[row].count; k++) begin
        issue_request(DIR_TABLE[row].mode, addr, DIR_TABLE[row].typed,
                      DIR_TABLE[row].present, DIR_TABLE[row].status);
        addr = addr + FILL_STEP;
      end
    end
    drain_set();

    // random sequences: bucket fills, mixed traffic, occasional clears
    while (requests_sent < TOTAL_REQUESTS) begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        // fill one bucket past its last segment
        hot_tag = 8'($urandom_range(0, 255));
        seq_len = $urandom_range(40, 56);
        seq_addrs.delete();
        repeat (seq_len) begin
          r = $urandom_range(0, 9);
          if (r < 7 || seq_addrs.size() == 0) begin
            addr = addr_in_bucket(hot_tag);
            seq_addrs.push_back(addr);
            issue_request(MODE_INSERT, addr, 1'b0, 1'b0, STAT_NONE);
          end else begin
            addr     = seq_addrs[$urandom_range(0, seq_addrs.size() - 1)];
            addr[63] = 1'($urandom_range(0, 1));
            issue_request((r == 9) ? MODE_ERASE : MODE_TEST, addr, 1'b0, 1'b0, STAT_NONE);
          end
        end
      end else if (r == 3) begin
        issue_request(MODE_CLEAR, {$urandom, $urandom}, 1'b0, 1'b0, STAT_NONE);
      end else begin
        seq_len = $urandom_range(8, 30);
        repeat (seq_len) begin
          r = $urandom_range(0, 99);
          issue_request((r < 30) ? MODE_TEST : (r < 65) ? MODE_INSERT :
                        (r < 98) ? MODE_ERASE : MODE_CLEAR,
                        pick_address(), 1'b0, 1'b0, STAT_NONE);
        end
      end
      if ($urandom_range(0, 7) == 0) drain_set();
    end

    drain_set();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d requests, %0d clears, %0d hits on existing keys",
             requests_sent, clears_sent, hits_seen);
    $display("inserts %0d, segment openings %0d, erases %0d, full buckets %0d",
             status_seen[STAT_INSERTED], status_seen[STAT_NEW_SEG],
             status_seen[STAT_ERASED], status_seen[STAT_FULL]);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/has_pkg.sv
design/has_front.sv
design/has_queue.sv
design/has_back.sv
design/hashed_address_set.sv
verif/tb_hashed_address_set.sv
